// File: hw/rtl/hctbp_pkg.sv
// shared types and constants for the huffman code table bit packer
`timescale 1ns / 1ps

package hctbp_pkg;

  // default sizes of the code table
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int PEND_W   = 7;
  localparam int CNT_W    = 3;
  localparam int ACC_W    = PEND_W + CODE_W + 1;
  localparam int BUF_W    = 4 * BYTE_W;
  localparam int BUFCNT_W = 3;

  // input word opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  // one table entry as seen by the packer
  typedef struct packed {
    logic [CODE_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } code_entry_t;

  // work handed from the input side to the packer stage
  typedef struct packed {
    logic encode;
    logic flush;
  } pk_req_t;

endpackage

// File: hw/rtl/hctbp_code_table.sv
// code table memory: load writes, encode lookups with a registered read
`timescale 1ns / 1ps

module hctbp_code_table #(
  parameter int SYMBOL_COUNT = hctbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hctbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic                           rd_en,
  input  logic [$clog2(SYMBOL_COUNT)-1:0] addr,
  input  logic [hctbp_pkg::CODE_W-1:0]   code_value,
  input  logic [hctbp_pkg::LEN_W-1:0]    code_length,
  output hctbp_pkg::code_entry_t         entry
);
  import hctbp_pkg::*;

  localparam int LIM   = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam logic [LEN_W-1:0] LIM_L = LEN_W'(LIM);

  code_entry_t       mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld;
  code_entry_t       rd_data;
  logic              rd_vld;
  logic [LEN_W-1:0]  len_c;
  logic [CODE_W-1:0] word_c;

  // clamp the length and keep only that many low bits of the code
  always_comb begin
    len_c = (code_length > LIM_L) ? LIM_L : code_length;
    if (len_c >= LEN_W'(CODE_W)) begin
      word_c = code_value;
    end else begin
      word_c = code_value & ((CODE_W'(1) << len_c) - CODE_W'(1));
    end
  end

  // table storage, contents undefined until written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= '{word: word_c, len: len_c};
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  // per entry written marks, unwritten entries read as zero length
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[addr];
      end
    end
  end

  assign entry = rd_vld ? rd_data : '0;

endmodule

// File: hw/rtl/hctbp_packer.sv
// bit packer: pending bits, byte buffer and output register
`timescale 1ns / 1ps

module hctbp_packer (
  input  logic                          clk,
  input  logic                          rst,
  input  hctbp_pkg::pk_req_t            req,
  output logic                          take,
  input  hctbp_pkg::code_entry_t        entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hctbp_pkg::BYTE_W-1:0]  packed_byte,
  output logic                          run_last
);
  import hctbp_pkg::*;

  logic                s1_valid;
  logic                s1_flush;
  logic [PEND_W-1:0]   pending_bits;
  logic [CNT_W-1:0]    pending_count;
  logic [BUF_W-1:0]    buf_data;
  logic [BUFCNT_W-1:0] buf_cnt;

  logic [LEN_W-1:0]    len;
  logic [CODE_W-1:0]   word;
  logic [ACC_W-1:0]    acc;
  logic [LEN_W-1:0]    total;
  logic [6:0]          sh;
  logic [ACC_W-1:0]    aligned;
  logic [BUFCNT_W-1:0] nbytes;
  logic [PEND_W-1:0]   pending_bits_next;
  logic [CNT_W-1:0]    pending_count_next;
  logic                pop;
  logic                buf_free_next;
  logic                s1_done;

  // merge looked-up code with pending bits
  always_comb begin
    len   = s1_flush ? '0 : entry.len;
    word  = s1_flush ? '0 : entry.word;
    acc   = (ACC_W'(pending_bits) << len) | ACC_W'(word);
    total = LEN_W'(pending_count) + len;
    sh    = 7'(ACC_W) - 7'(total);
    aligned = acc << sh;
    if (s1_flush) begin
      nbytes             = (pending_count != '0) ? BUFCNT_W'(1) : '0;
      pending_bits_next  = '0;
      pending_count_next = '0;
    end else begin
      nbytes             = total[LEN_W-1:CNT_W];
      pending_bits_next  = acc[PEND_W-1:0] & (PEND_W'(7'h7F) >> (CNT_W'(7) - total[CNT_W-1:0]));
      pending_count_next = total[CNT_W-1:0];
    end
  end

  // handshake between stage, buffer and output register
  assign pop           = (buf_cnt != '0) && (!out_valid || out_ready);
  assign buf_free_next = (buf_cnt == '0) || ((buf_cnt == BUFCNT_W'(1)) && pop);
  assign s1_done       = s1_valid && ((nbytes == '0) || buf_free_next);
  assign take          = !s1_valid || s1_done;

  // packer stage and pending bit register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s1_flush      <= 1'b0;
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      if (take) begin
        s1_valid <= req.encode || req.flush;
        s1_flush <= req.flush;
      end
      if (s1_done) begin
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
      end
    end
  end

  // byte buffer, drains one byte a cycle while the output register can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
    end else if (s1_done && (nbytes != '0)) begin
      buf_cnt <= nbytes;
    end else if (pop) begin
      buf_cnt <= buf_cnt - BUFCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && (nbytes != '0)) begin
      buf_data <= aligned[ACC_W-1 -: BUF_W];
    end else if (pop) begin
      buf_data <= buf_data << BYTE_W;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      packed_byte <= buf_data[BUF_W-1 -: BYTE_W];
      run_last    <= (buf_cnt == BUFCNT_W'(1));
    end
  end

  // buffer never holds more than one item's bytes
  a_buf_cnt: assert property (@(posedge clk) disable iff (rst)
    buf_cnt <= BUFCNT_W'(4))
    else $error("byte buffer overfilled");

  // a popped byte shows up in the output register
  a_pop_out: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped byte not presented");

  // a stalled stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_done) |=> (s1_valid && $stable(s1_flush)))
    else $error("stalled stage lost its item");

  // flush leaves nothing pending
  a_flush_clr: assert property (@(posedge clk) disable iff (rst)
    (s1_done && s1_flush) |=> (pending_count == '0))
    else $error("flush left pending bits");

endmodule

// File: hw/rtl/huffman_code_table_bit_packer.sv
// Top level of the static huffman code table bit packer.
// Path of an encode or flush word: table read register, packer stage, byte buffer, output register.
// Throughput: one input word per cycle while each word yields at most one byte and the output
// is not stalled; a multi-byte word holds back later byte words while the output port drains it.
// Reset clears pending bits and the per entry written marks; table contents stay undefined
// but unwritten entries read as zero length, so no clearing pass is needed.
`timescale 1ns / 1ps

module huffman_code_table_bit_packer #(
  parameter int MAX_CODE_LEN = hctbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hctbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hctbp_pkg::OP_W-1:0]    op,
  input  logic [hctbp_pkg::SYM_W-1:0]   symbol,
  input  logic [hctbp_pkg::CODE_W-1:0]  code_value,
  input  logic [hctbp_pkg::LEN_W-1:0]   code_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hctbp_pkg::BYTE_W-1:0]  packed_byte,
  output logic                          run_last
);
  import hctbp_pkg::*;

  localparam int IDX_W = $clog2(SYMBOL_COUNT);

  logic        in_fire;
  logic        in_range;
  pk_req_t     req;
  code_entry_t entry;

  // decode the accepted word
  assign in_fire    = in_valid && in_ready;
  assign in_range   = (9'(symbol) < 9'(SYMBOL_COUNT));
  assign req.encode = in_fire && (op == OP_ENCODE) && in_range;
  assign req.flush  = in_fire && (op == OP_FLUSH);

  hctbp_code_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (in_fire && (op == OP_LOAD) && in_range),
    .rd_en       (req.encode),
    .addr        (symbol[IDX_W-1:0]),
    .code_value  (code_value),
    .code_length (code_length),
    .entry       (entry)
  );

  hctbp_packer u_packer (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .take        (in_ready),
    .entry       (entry),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_byte (packed_byte),
    .run_last    (run_last)
  );

endmodule
